/* hw/rtl/bcc_pkg.sv */
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared widths, face codes, stage payload types and helpers for the
// box and circle contact pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package bcc_pkg;

  // Default fraction bits of the Q format
  localparam int FRAC_BITS_DEF = 16;

  // Field widths
  localparam int CRD_W = 32;          // signed coordinate
  localparam int MAG_W = 31;          // unsigned extent, radius, scale
  localparam int NRM_W = 18;          // signed normal component
  localparam int EXT_W = 33;          // saturated scaled half extent
  localparam int OFS_W = 36;          // signed offsets around the box
  localparam int SUM_W = 37;          // coordinate plus offset
  localparam int RIM_W = 34;          // signed rim offset

  localparam logic [EXT_W-1:0] EXT_MAX = '1;
  localparam logic [MAG_W-1:0] RAD_MAX = '1;

  // Face the box point snaps to when the circle centre is inside
  typedef enum logic [1:0] {
    FACE_PX,
    FACE_NX,
    FACE_PY,
    FACE_NY
  } face_t;

  // Geometry carried through the first root and divide
  typedef struct packed {
    logic                    hit;
    logic                    in_box;
    face_t                   face;
    logic                    neg_x;
    logic                    neg_y;
    logic signed [OFS_W-1:0] kx;
    logic signed [OFS_W-1:0] ky;
    logic [MAG_W-1:0]        r;
    logic signed [CRD_W-1:0] bx;
    logic signed [CRD_W-1:0] by;
    logic signed [CRD_W-1:0] cx;
    logic signed [CRD_W-1:0] cy;
  } geo_t;

  // Geometry plus the rim numerators
  typedef struct packed {
    geo_t                geo;
    logic [2*MAG_W-1:0]  mx;
    logic [2*MAG_W-1:0]  my;
  } geo_prod_t;

  // Contact points and the folded difference
  typedef struct packed {
    logic                    hit;
    logic signed [CRD_W-1:0] pbx;
    logic signed [CRD_W-1:0] pby;
    logic signed [CRD_W-1:0] pcx;
    logic signed [CRD_W-1:0] pcy;
    logic [MAG_W-1:0]        ax;
    logic [MAG_W-1:0]        ay;
    logic                    neg_x;
    logic                    neg_y;
    logic                    half;
  } pts_t;

  // Points plus the length root
  typedef struct packed {
    pts_t        pts;
    logic [31:0] l0;
  } fin_t;

  // Saturate a wide signed sum to the coordinate range
  function automatic logic signed [CRD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [CRD_W-1:0] res;
    if (v[SUM_W-1:CRD_W-1] == {(SUM_W-CRD_W+1){v[SUM_W-1]}}) begin
      res = v[CRD_W-1:0];
    end else if (v[SUM_W-1]) begin
      res = {1'b1, {(CRD_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(CRD_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/bcc_sqrt.sv */
// ----------------------------------------------------------------------------
// bcc_sqrt
// Pipelined integer square root, one root bit per stage, with a side
// payload that travels alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module bcc_sqrt #(
  parameter int RAD_W  = 64,
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [RAD_W-1:0]     in_rad,
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_vld,
  output logic [RAD_W/2-1:0]   out_root,
  output logic [SIDE_W-1:0]    out_side
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  logic [ROOT_W:0]       vld;
  logic [RAD_W-1:0]      rad  [ROOT_W+1];
  logic [REM_W-1:0]      rem  [ROOT_W+1];
  logic [ROOT_W-1:0]     root [ROOT_W+1];
  logic [SIDE_W-1:0]     side [ROOT_W+1];

  logic [REM_W+1:0]      cur   [ROOT_W];
  logic [REM_W+1:0]      trial [ROOT_W];
  logic [REM_W+1:0]      diff  [ROOT_W];
  logic [ROOT_W-1:0]     take;

  // Try one root bit per stage
  always_comb begin
    for (int i = 0; i < ROOT_W; i++) begin
      cur[i]   = {rem[i], rad[i][RAD_W-1 -: 2]};
      trial[i] = {2'b00, root[i], 2'b01};
      take[i]  = cur[i] >= trial[i];
      diff[i]  = cur[i] - trial[i];
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[ROOT_W-1:0], in_vld};
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      rad[0]  <= in_rad;
      rem[0]  <= '0;
      root[0] <= '0;
      side[0] <= in_side;
      for (int i = 0; i < ROOT_W; i++) begin
        rad[i+1]  <= rad[i] << 2;
        rem[i+1]  <= take[i] ? diff[i][REM_W-1:0] : cur[i][REM_W-1:0];
        root[i+1] <= {root[i][ROOT_W-2:0], take[i]};
        side[i+1] <= side[i];
      end
    end
  end

  assign out_vld  = vld[ROOT_W];
  assign out_root = root[ROOT_W];
  assign out_side = side[ROOT_W];

endmodule

`default_nettype wire

/* hw/rtl/bcc_div.sv */
// ----------------------------------------------------------------------------
// bcc_div
// Pipelined two-lane restoring divider with a shared divisor, one
// quotient bit per stage. The quotient must fit in QUO_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module bcc_div #(
  parameter int NUM_W  = 63,
  parameter int DEN_W  = 32,
  parameter int QUO_W  = 32,
  parameter int SIDE_W = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  logic [NUM_W-1:0]   in_num_a,
  input  logic [NUM_W-1:0]   in_num_b,
  input  logic [DEN_W-1:0]   in_den,
  input  logic [SIDE_W-1:0]  in_side,
  output logic               out_vld,
  output logic [QUO_W-1:0]   out_quo_a,
  output logic [QUO_W-1:0]   out_quo_b,
  output logic [SIDE_W-1:0]  out_side
);

  localparam int RW = DEN_W + 1;

  logic [QUO_W:0]       vld;
  logic [RW-1:0]        rem_a [QUO_W+1];
  logic [RW-1:0]        rem_b [QUO_W+1];
  logic [QUO_W-1:0]     low_a [QUO_W+1];
  logic [QUO_W-1:0]     low_b [QUO_W+1];
  logic [QUO_W-1:0]     quo_a [QUO_W+1];
  logic [QUO_W-1:0]     quo_b [QUO_W+1];
  logic [DEN_W-1:0]     den   [QUO_W+1];
  logic [SIDE_W-1:0]    side  [QUO_W+1];

  logic [RW-1:0]        cur_a [QUO_W];
  logic [RW-1:0]        cur_b [QUO_W];
  logic [RW-1:0]        nrm_a [QUO_W];
  logic [RW-1:0]        nrm_b [QUO_W];
  logic [QUO_W-1:0]     take_a;
  logic [QUO_W-1:0]     take_b;

  // Shift in one dividend bit and try a subtract per stage
  always_comb begin
    for (int i = 0; i < QUO_W; i++) begin
      cur_a[i]  = {rem_a[i][RW-2:0], low_a[i][QUO_W-1]};
      cur_b[i]  = {rem_b[i][RW-2:0], low_b[i][QUO_W-1]};
      take_a[i] = cur_a[i] >= {1'b0, den[i]};
      take_b[i] = cur_b[i] >= {1'b0, den[i]};
      nrm_a[i]  = take_a[i] ? cur_a[i] - {1'b0, den[i]} : cur_a[i];
      nrm_b[i]  = take_b[i] ? cur_b[i] - {1'b0, den[i]} : cur_b[i];
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QUO_W-1:0], in_vld};
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      rem_a[0] <= RW'(in_num_a >> QUO_W);
      rem_b[0] <= RW'(in_num_b >> QUO_W);
      low_a[0] <= in_num_a[QUO_W-1:0];
      low_b[0] <= in_num_b[QUO_W-1:0];
      quo_a[0] <= '0;
      quo_b[0] <= '0;
      den[0]   <= in_den;
      side[0]  <= in_side;
      for (int i = 0; i < QUO_W; i++) begin
        rem_a[i+1] <= nrm_a[i];
        rem_b[i+1] <= nrm_b[i];
        low_a[i+1] <= low_a[i] << 1;
        low_b[i+1] <= low_b[i] << 1;
        quo_a[i+1] <= {quo_a[i][QUO_W-2:0], take_a[i]};
        quo_b[i+1] <= {quo_b[i][QUO_W-2:0], take_b[i]};
        den[i+1]   <= den[i];
        side[i+1]  <= side[i];
      end
    end
  end

  assign out_vld   = vld[QUO_W];
  assign out_quo_a = quo_a[QUO_W];
  assign out_quo_b = quo_b[QUO_W];
  assign out_side  = side[QUO_W];

endmodule

`default_nettype wire

/* hw/rtl/box_circle_contact.sv */
// ----------------------------------------------------------------------------
// box_circle_contact
// Axis-aligned box against circle contact in signed fixed point: scale,
// clamp, inside face snap, rim point by root and divide, then normal and
// depth by a second root and divide.
//
//   channel | signals                         | request
//   --------+---------------------------------+------------------------------
//   in      | in_valid / in_ready, 11 fields  | one box and circle pair
//   out     | out_valid / out_ready, 8 fields | one contact result
//
// One request enters every cycle while the output is not stalled; each gives exactly one result.
// Most of the pipeline depth lies in the two 32-stage square roots and the two
// bit-per-stage dividers; the normal divider grows with FRAC_BITS (Q16.16 default).
// Reset clears every valid bit; payload registers are not reset.
// A stalled output holds the whole pipeline with one shared enable.
// ----------------------------------------------------------------------------
`default_nettype none

module box_circle_contact #(
  parameter int FRAC_BITS = bcc_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [bcc_pkg::CRD_W-1:0]  box_center_x,
  input  logic signed [bcc_pkg::CRD_W-1:0]  box_center_y,
  input  logic [bcc_pkg::MAG_W-1:0]         box_half_width,
  input  logic [bcc_pkg::MAG_W-1:0]         box_half_height,
  input  logic [bcc_pkg::MAG_W-1:0]         box_scale_x,
  input  logic [bcc_pkg::MAG_W-1:0]         box_scale_y,
  input  logic signed [bcc_pkg::CRD_W-1:0]  circle_center_x,
  input  logic signed [bcc_pkg::CRD_W-1:0]  circle_center_y,
  input  logic [bcc_pkg::MAG_W-1:0]         circle_radius,
  input  logic [bcc_pkg::MAG_W-1:0]         circle_scale_x,
  input  logic [bcc_pkg::MAG_W-1:0]         circle_scale_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              hit,
  output logic signed [bcc_pkg::CRD_W-1:0]  box_point_x,
  output logic signed [bcc_pkg::CRD_W-1:0]  box_point_y,
  output logic signed [bcc_pkg::CRD_W-1:0]  circle_point_x,
  output logic signed [bcc_pkg::CRD_W-1:0]  circle_point_y,
  output logic signed [bcc_pkg::NRM_W-1:0]  normal_x,
  output logic signed [bcc_pkg::NRM_W-1:0]  normal_y,
  output logic [bcc_pkg::MAG_W-1:0]         depth
);

  import bcc_pkg::*;

  localparam int PROD_W = 2 * MAG_W;
  localparam int OX_W   = CRD_W + 1;
  localparam int SQ_W   = 64;
  localparam int ROOT_W = SQ_W / 2;
  localparam int NUM1_W = PROD_W + 1;
  localparam int NUM2_W = MAG_W + FRAC_BITS + 1;
  localparam int QUO2_W = FRAC_BITS + 2;
  localparam int LEN_W  = ROOT_W + 1;

  localparam logic [31:0] NRM_POS_LIM = 32'd131071;
  localparam logic [31:0] NRM_NEG_LIM = 32'd131072;

  logic en;

  // Hold every stage while the result waits
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // --------------------------------------------------------------------------
  // Stage 1: products and centre offset
  // --------------------------------------------------------------------------
  logic                    s1_vld;
  logic [PROD_W-1:0]       s1_px, s1_py, s1_pr;
  logic signed [OX_W-1:0]  s1_ox, s1_oy;
  logic signed [CRD_W-1:0] s1_bx, s1_by, s1_cx, s1_cy;
  logic [MAG_W-1:0]        smax;

  assign smax = (circle_scale_x > circle_scale_y) ? circle_scale_x : circle_scale_y;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_px <= PROD_W'(box_half_width) * PROD_W'(box_scale_x);
      s1_py <= PROD_W'(box_half_height) * PROD_W'(box_scale_y);
      s1_pr <= PROD_W'(circle_radius) * PROD_W'(smax);
      s1_ox <= OX_W'(circle_center_x) - OX_W'(box_center_x);
      s1_oy <= OX_W'(circle_center_y) - OX_W'(box_center_y);
      s1_bx <= box_center_x;
      s1_by <= box_center_y;
      s1_cx <= circle_center_x;
      s1_cy <= circle_center_y;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: truncate and saturate scaled extents and radius
  // --------------------------------------------------------------------------
  logic                    s2_vld;
  logic [EXT_W-1:0]        s2_ex, s2_ey;
  logic [MAG_W-1:0]        s2_r;
  logic signed [OX_W-1:0]  s2_ox, s2_oy;
  logic signed [CRD_W-1:0] s2_bx, s2_by, s2_cx, s2_cy;
  logic [PROD_W-1:0]       ex_w, ey_w, r_w;

  assign ex_w = s1_px >> FRAC_BITS;
  assign ey_w = s1_py >> FRAC_BITS;
  assign r_w  = s1_pr >> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ex <= (ex_w > PROD_W'(EXT_MAX)) ? EXT_MAX : ex_w[EXT_W-1:0];
      s2_ey <= (ey_w > PROD_W'(EXT_MAX)) ? EXT_MAX : ey_w[EXT_W-1:0];
      s2_r  <= (r_w > PROD_W'(RAD_MAX)) ? RAD_MAX : r_w[MAG_W-1:0];
      s2_ox <= s1_ox;
      s2_oy <= s1_oy;
      s2_bx <= s1_bx;
      s2_by <= s1_by;
      s2_cx <= s1_cx;
      s2_cy <= s1_cy;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: clamp offset to the box, face distances
  // --------------------------------------------------------------------------
  logic                    s3_vld;
  logic                    s3_inside;
  logic signed [OFS_W-1:0] s3_kx, s3_ky, s3_ex, s3_ey;
  logic signed [OFS_W-1:0] s3_dpx, s3_dnx, s3_dpy, s3_dny, s3_dx, s3_dy;
  logic [MAG_W-1:0]        s3_r;
  logic signed [CRD_W-1:0] s3_bx, s3_by, s3_cx, s3_cy;
  logic signed [OFS_W-1:0] ex3, ey3, ox3, oy3, kx3, ky3;
  logic                    lo_x, hi_x, lo_y, hi_y;

  always_comb begin
    ex3  = signed'(OFS_W'(s2_ex));
    ey3  = signed'(OFS_W'(s2_ey));
    ox3  = OFS_W'(s2_ox);
    oy3  = OFS_W'(s2_oy);
    lo_x = ox3 < -ex3;
    hi_x = ox3 > ex3;
    lo_y = oy3 < -ey3;
    hi_y = oy3 > ey3;
    kx3  = lo_x ? -ex3 : (hi_x ? ex3 : ox3);
    ky3  = lo_y ? -ey3 : (hi_y ? ey3 : oy3);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_inside <= !lo_x && !hi_x && !lo_y && !hi_y;
      s3_kx     <= kx3;
      s3_ky     <= ky3;
      s3_ex     <= ex3;
      s3_ey     <= ey3;
      s3_dpx    <= ex3 - ox3;
      s3_dnx    <= ex3 + ox3;
      s3_dpy    <= ey3 - oy3;
      s3_dny    <= ey3 + oy3;
      s3_dx     <= kx3 - ox3;
      s3_dy     <= ky3 - oy3;
      s3_r      <= s2_r;
      s3_bx     <= s2_bx;
      s3_by     <= s2_by;
      s3_cx     <= s2_cx;
      s3_cy     <= s2_cy;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: nearest face snap, outside distance early miss
  // --------------------------------------------------------------------------
  logic                    s4_vld;
  geo_t                    s4_geo;
  logic [MAG_W-1:0]        s4_axs, s4_ays;
  logic                    s4_missa;
  face_t                   face4;
  logic signed [OFS_W-1:0] kx4, ky4;
  logic [OFS_W-1:0]        ax4, ay4;

  // Pick the face with ties in +x, -x, +y, -y order
  always_comb begin
    priority if (s3_dpx <= s3_dnx && s3_dpx <= s3_dpy && s3_dpx <= s3_dny) begin
      face4 = FACE_PX;
    end else if (s3_dnx <= s3_dpy && s3_dnx <= s3_dny) begin
      face4 = FACE_NX;
    end else if (s3_dpy <= s3_dny) begin
      face4 = FACE_PY;
    end else begin
      face4 = FACE_NY;
    end
  end

  // Snap the box point when inside
  always_comb begin
    kx4 = s3_kx;
    ky4 = s3_ky;
    if (s3_inside) begin
      unique case (face4)
        FACE_PX: kx4 = s3_ex;
        FACE_NX: kx4 = -s3_ex;
        FACE_PY: ky4 = s3_ey;
        FACE_NY: ky4 = -s3_ey;
      endcase
    end
  end

  assign ax4 = s3_dx[OFS_W-1] ? OFS_W'(-s3_dx) : OFS_W'(s3_dx);
  assign ay4 = s3_dy[OFS_W-1] ? OFS_W'(-s3_dy) : OFS_W'(s3_dy);

  always_ff @(posedge clk) begin
    if (en) begin
      s4_geo.hit    <= 1'b0;
      s4_geo.in_box <= s3_inside;
      s4_geo.face   <= face4;
      s4_geo.neg_x  <= s3_dx[OFS_W-1];
      s4_geo.neg_y  <= s3_dy[OFS_W-1];
      s4_geo.kx     <= kx4;
      s4_geo.ky     <= ky4;
      s4_geo.r      <= s3_r;
      s4_geo.bx     <= s3_bx;
      s4_geo.by     <= s3_by;
      s4_geo.cx     <= s3_cx;
      s4_geo.cy     <= s3_cy;
      s4_axs        <= ax4[MAG_W-1:0];
      s4_ays        <= ay4[MAG_W-1:0];
      s4_missa      <= (ax4 >= OFS_W'(s3_r)) || (ay4 >= OFS_W'(s3_r));
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: squares and rim numerators
  // --------------------------------------------------------------------------
  logic                    s5_vld;
  geo_t                    s5_geo;
  logic                    s5_missa;
  logic [PROD_W-1:0]       s5_sqx, s5_sqy, s5_rr, s5_mx, s5_my;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_sqx   <= PROD_W'(s4_axs) * PROD_W'(s4_axs);
      s5_sqy   <= PROD_W'(s4_ays) * PROD_W'(s4_ays);
      s5_rr    <= PROD_W'(s4_geo.r) * PROD_W'(s4_geo.r);
      s5_mx    <= PROD_W'(s4_axs) * PROD_W'(s4_geo.r);
      s5_my    <= PROD_W'(s4_ays) * PROD_W'(s4_geo.r);
      s5_geo   <= s4_geo;
      s5_missa <= s4_missa;
    end
  end

  // --------------------------------------------------------------------------
  // First root: distance from the circle centre to the box point
  // --------------------------------------------------------------------------
  logic [SQ_W-1:0]         sq5;
  geo_prod_t               side5;
  logic                    sr1_vld;
  logic [ROOT_W-1:0]       sr1_root;
  geo_prod_t               sr1_side;

  always_comb begin
    sq5          = SQ_W'(s5_sqx) + SQ_W'(s5_sqy);
    side5.geo    = s5_geo;
    side5.geo.hit = s5_geo.in_box || !(s5_missa || (sq5 >= SQ_W'(s5_rr)));
    side5.mx     = s5_mx;
    side5.my     = s5_my;
  end

  bcc_sqrt #(
    .RAD_W  (SQ_W),
    .SIDE_W ($bits(geo_prod_t))
  ) u_sqrt_rim (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s5_vld),
    .in_rad   (sq5),
    .in_side  (side5),
    .out_vld  (sr1_vld),
    .out_root (sr1_root),
    .out_side (sr1_side)
  );

  // --------------------------------------------------------------------------
  // First divide: rim offset, rounded half away from zero
  // --------------------------------------------------------------------------
  logic [NUM1_W-1:0]       num1_a, num1_b;
  logic                    dv1_vld;
  logic [ROOT_W-1:0]       dv1_qa, dv1_qb;
  geo_t                    dv1_geo;

  assign num1_a = NUM1_W'(sr1_side.mx) + NUM1_W'(sr1_root >> 1);
  assign num1_b = NUM1_W'(sr1_side.my) + NUM1_W'(sr1_root >> 1);

  bcc_div #(
    .NUM_W  (NUM1_W),
    .DEN_W  (ROOT_W),
    .QUO_W  (ROOT_W),
    .SIDE_W ($bits(geo_t))
  ) u_div_rim (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_vld    (sr1_vld),
    .in_num_a  (num1_a),
    .in_num_b  (num1_b),
    .in_den    (sr1_root),
    .in_side   (sr1_side.geo),
    .out_vld   (dv1_vld),
    .out_quo_a (dv1_qa),
    .out_quo_b (dv1_qb),
    .out_side  (dv1_geo)
  );

  // --------------------------------------------------------------------------
  // Stage 7: rim offset select and saturated contact points
  // --------------------------------------------------------------------------
  logic                    s7_vld;
  logic                    s7_hit;
  logic signed [CRD_W-1:0] s7_pbx, s7_pby, s7_pcx, s7_pcy;
  logic signed [RIM_W-1:0] rimx7, rimy7, r7, qx7, qy7;

  always_comb begin
    r7    = signed'(RIM_W'(dv1_geo.r));
    qx7   = signed'(RIM_W'(dv1_qa));
    qy7   = signed'(RIM_W'(dv1_qb));
    rimx7 = '0;
    rimy7 = '0;
    if (dv1_geo.in_box) begin
      unique case (dv1_geo.face)
        FACE_PX: rimx7 = -r7;
        FACE_NX: rimx7 = r7;
        FACE_PY: rimy7 = -r7;
        FACE_NY: rimy7 = r7;
      endcase
    end else begin
      rimx7 = dv1_geo.neg_x ? -qx7 : qx7;
      rimy7 = dv1_geo.neg_y ? -qy7 : qy7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_hit <= dv1_geo.hit;
      s7_pbx <= sat32(SUM_W'(dv1_geo.bx) + SUM_W'(dv1_geo.kx));
      s7_pby <= sat32(SUM_W'(dv1_geo.by) + SUM_W'(dv1_geo.ky));
      s7_pcx <= sat32(SUM_W'(dv1_geo.cx) + SUM_W'(rimx7));
      s7_pcy <= sat32(SUM_W'(dv1_geo.cy) + SUM_W'(rimy7));
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: point difference, halve when wide
  // --------------------------------------------------------------------------
  logic                    s8_vld;
  pts_t                    s8_pts;
  logic signed [OX_W-1:0]  fx8, fy8;
  logic [OX_W-1:0]         ax8, ay8, axh8, ayh8;
  logic                    half8;

  always_comb begin
    fx8   = OX_W'(s7_pcx) - OX_W'(s7_pbx);
    fy8   = OX_W'(s7_pcy) - OX_W'(s7_pby);
    ax8   = fx8[OX_W-1] ? OX_W'(-fx8) : OX_W'(fx8);
    ay8   = fy8[OX_W-1] ? OX_W'(-fy8) : OX_W'(fy8);
    half8 = ax8[OX_W-1] || ax8[OX_W-2] || ay8[OX_W-1] || ay8[OX_W-2];
    axh8  = half8 ? (ax8 >> 1) : ax8;
    ayh8  = half8 ? (ay8 >> 1) : ay8;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_pts.hit   <= s7_hit;
      s8_pts.pbx   <= s7_pbx;
      s8_pts.pby   <= s7_pby;
      s8_pts.pcx   <= s7_pcx;
      s8_pts.pcy   <= s7_pcy;
      s8_pts.ax    <= axh8[MAG_W-1:0];
      s8_pts.ay    <= ayh8[MAG_W-1:0];
      s8_pts.neg_x <= fx8[OX_W-1];
      s8_pts.neg_y <= fy8[OX_W-1];
      s8_pts.half  <= half8;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 9: squares of the folded difference
  // --------------------------------------------------------------------------
  logic                    s9_vld;
  pts_t                    s9_pts;
  logic [PROD_W-1:0]       s9_sqx, s9_sqy;

  always_ff @(posedge clk) begin
    if (en) begin
      s9_sqx <= PROD_W'(s8_pts.ax) * PROD_W'(s8_pts.ax);
      s9_sqy <= PROD_W'(s8_pts.ay) * PROD_W'(s8_pts.ay);
      s9_pts <= s8_pts;
    end
  end

  // --------------------------------------------------------------------------
  // Second root: length between the contact points
  // --------------------------------------------------------------------------
  logic [SQ_W-1:0]         sq9;
  logic                    sr2_vld;
  logic [ROOT_W-1:0]       sr2_root;
  pts_t                    sr2_pts;

  assign sq9 = SQ_W'(s9_sqx) + SQ_W'(s9_sqy);

  bcc_sqrt #(
    .RAD_W  (SQ_W),
    .SIDE_W ($bits(pts_t))
  ) u_sqrt_len (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s9_vld),
    .in_rad   (sq9),
    .in_side  (s9_pts),
    .out_vld  (sr2_vld),
    .out_root (sr2_root),
    .out_side (sr2_pts)
  );

  // --------------------------------------------------------------------------
  // Second divide: unit normal, rounded half away from zero
  // --------------------------------------------------------------------------
  logic [NUM2_W-1:0]       num2_a, num2_b;
  fin_t                    side2;
  logic                    dv2_vld;
  logic [QUO2_W-1:0]       dv2_qa, dv2_qb;
  fin_t                    dv2_fin;

  assign num2_a    = (NUM2_W'(sr2_pts.ax) << FRAC_BITS) + NUM2_W'(sr2_root >> 1);
  assign num2_b    = (NUM2_W'(sr2_pts.ay) << FRAC_BITS) + NUM2_W'(sr2_root >> 1);
  assign side2.pts = sr2_pts;
  assign side2.l0  = sr2_root;

  bcc_div #(
    .NUM_W  (NUM2_W),
    .DEN_W  (ROOT_W),
    .QUO_W  (QUO2_W),
    .SIDE_W ($bits(fin_t))
  ) u_div_nrm (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_vld    (sr2_vld),
    .in_num_a  (num2_a),
    .in_num_b  (num2_b),
    .in_den    (sr2_root),
    .in_side   (side2),
    .out_vld   (dv2_vld),
    .out_quo_a (dv2_qa),
    .out_quo_b (dv2_qb),
    .out_side  (dv2_fin)
  );

  // --------------------------------------------------------------------------
  // Output register: depth, clamped normal, empty result on a miss
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0]        len_o;
  logic [MAG_W-1:0]        dep_o;
  logic [31:0]             qx_o, qy_o;
  logic signed [NRM_W-1:0] nx_o, ny_o;

  always_comb begin
    len_o = LEN_W'(dv2_fin.l0) << dv2_fin.pts.half;
    dep_o = (len_o > LEN_W'(RAD_MAX)) ? RAD_MAX : len_o[MAG_W-1:0];
    qx_o  = 32'(dv2_qa);
    qy_o  = 32'(dv2_qb);
    if (dv2_fin.pts.neg_x) begin
      nx_o = (qx_o > NRM_NEG_LIM) ? {1'b1, {(NRM_W-1){1'b0}}} : NRM_W'(0) - qx_o[NRM_W-1:0];
    end else begin
      nx_o = (qx_o > NRM_POS_LIM) ? {1'b0, {(NRM_W-1){1'b1}}} : qx_o[NRM_W-1:0];
    end
    if (dv2_fin.pts.neg_y) begin
      ny_o = (qy_o > NRM_NEG_LIM) ? {1'b1, {(NRM_W-1){1'b0}}} : NRM_W'(0) - qy_o[NRM_W-1:0];
    end else begin
      ny_o = (qy_o > NRM_POS_LIM) ? {1'b0, {(NRM_W-1){1'b1}}} : qy_o[NRM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!dv2_fin.pts.hit) begin
        hit            <= 1'b0;
        box_point_x    <= '0;
        box_point_y    <= '0;
        circle_point_x <= '0;
        circle_point_y <= '0;
        normal_x       <= '0;
        normal_y       <= '0;
        depth          <= '0;
      end else begin
        hit            <= 1'b1;
        box_point_x    <= dv2_fin.pts.pbx;
        box_point_y    <= dv2_fin.pts.pby;
        circle_point_x <= dv2_fin.pts.pcx;
        circle_point_y <= dv2_fin.pts.pcy;
        if (dv2_fin.l0 == '0) begin
          normal_x <= '0;
          normal_y <= '0;
          depth    <= '0;
        end else begin
          normal_x <= nx_o;
          normal_y <= ny_o;
          depth    <= dep_o;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Valid bits of the top-level stages
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld    <= 1'b0;
      s2_vld    <= 1'b0;
      s3_vld    <= 1'b0;
      s4_vld    <= 1'b0;
      s5_vld    <= 1'b0;
      s7_vld    <= 1'b0;
      s8_vld    <= 1'b0;
      s9_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_vld    <= in_valid;
      s2_vld    <= s1_vld;
      s3_vld    <= s2_vld;
      s4_vld    <= s3_vld;
      s5_vld    <= s4_vld;
      s7_vld    <= dv1_vld;
      s8_vld    <= s7_vld;
      s9_vld    <= s8_vld;
      out_valid <= dv2_vld;
    end
  end

endmodule

`default_nettype wire
